### src/srd_pkg.sv
package srd_pkg;

  localparam int LENGTH_WIDTH = 16;
  localparam int PADDR_W      = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] COBS_END   = 8'h00;
  localparam logic [7:0] COBS_FULL  = 8'hFF;
  localparam logic [7:0] SLIP_END   = 8'hC0;
  localparam logic [7:0] SLIP_ESC   = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  localparam logic [7:0]  LINE_DELIM_RESET = 8'd10;
  localparam logic [15:0] MAX_BYTES_RESET  = 16'd2048;

  typedef enum logic [1:0] {
    MODE_RAW  = 2'd0,
    MODE_LINE = 2'd1,
    MODE_COBS = 2'd2,
    MODE_SLIP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_DECODE   = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    REG_CODEC_MODE = 2'd0,
    REG_LINE_DELIM = 2'd1,
    REG_MAX_BYTES  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic        mode_wr;
    mode_t       codec_mode;
    logic [7:0]  line_delimiter;
    logic [15:0] max_frame_bytes;
  } cfg_t;

  // one accepted byte worth of results; two is set when a frame-done follows
  typedef struct packed {
    logic       two;
    kind_t      kind;
    logic [7:0] data;
    err_t       err;
  } rec_t;

endpackage

### src/srd_front.sv
module srd_front (
  input  logic          clk,
  input  logic          rst,
  input  srd_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output logic          push,
  output srd_pkg::rec_t rec
);

  logic [srd_pkg::LENGTH_WIDTH-1:0] frame_length, frame_length_next;
  logic       slip_escape_pending, slip_escape_pending_next;
  logic [7:0] group_bytes_left, group_bytes_left_next;
  logic       group_was_full, group_was_full_next;
  logic       decoded_nonempty, decoded_nonempty_next;

  logic at_limit;
  logic has_result;
  logic clear;

  assign at_limit = (32'(frame_length) >= 32'(cfg.max_frame_bytes)) || (&frame_length);

  always_comb begin
    frame_length_next        = frame_length;
    slip_escape_pending_next = slip_escape_pending;
    group_bytes_left_next    = group_bytes_left;
    group_was_full_next      = group_was_full;
    decoded_nonempty_next    = decoded_nonempty;
    has_result = 1'b0;
    clear      = 1'b0;
    rec.two  = 1'b0;
    rec.kind = srd_pkg::KIND_DATA;
    rec.data = rx_byte;
    rec.err  = srd_pkg::ERR_NONE;

    case (cfg.codec_mode)
      srd_pkg::MODE_RAW: begin
        has_result = 1'b1;
        rec.two    = 1'b1;
      end
      srd_pkg::MODE_LINE: begin
        if (rx_byte == cfg.line_delimiter) begin
          has_result = decoded_nonempty;
          rec.kind   = srd_pkg::KIND_DONE;
          clear      = 1'b1;
        end else if (at_limit) begin
          has_result = 1'b1;
          rec.kind   = srd_pkg::KIND_ABORT;
          rec.err    = srd_pkg::ERR_OVERFLOW;
          clear      = 1'b1;
        end else begin
          has_result            = 1'b1;
          frame_length_next     = frame_length + 1'b1;
          decoded_nonempty_next = 1'b1;
        end
      end
      srd_pkg::MODE_COBS: begin
        if (rx_byte == srd_pkg::COBS_END) begin
          clear = 1'b1;
          if (frame_length != '0 && group_bytes_left != 8'd0) begin
            has_result = 1'b1;
            rec.kind   = srd_pkg::KIND_ABORT;
            rec.err    = srd_pkg::ERR_DECODE;
          end else begin
            has_result = decoded_nonempty;
            rec.kind   = srd_pkg::KIND_DONE;
          end
        end else if (at_limit) begin
          has_result = 1'b1;
          rec.kind   = srd_pkg::KIND_ABORT;
          rec.err    = srd_pkg::ERR_OVERFLOW;
          clear      = 1'b1;
        end else begin
          frame_length_next = frame_length + 1'b1;
          if (group_bytes_left == 8'd0) begin
            // code byte: the previous short group implies a zero
            if (frame_length != '0 && !group_was_full) begin
              has_result            = 1'b1;
              rec.data              = 8'h00;
              decoded_nonempty_next = 1'b1;
            end
            group_bytes_left_next = rx_byte - 8'd1;
            group_was_full_next   = (rx_byte == srd_pkg::COBS_FULL);
          end else begin
            has_result            = 1'b1;
            group_bytes_left_next = group_bytes_left - 8'd1;
            decoded_nonempty_next = 1'b1;
          end
        end
      end
      default: begin
        if (rx_byte == srd_pkg::SLIP_END) begin
          has_result = decoded_nonempty;
          rec.kind   = srd_pkg::KIND_DONE;
          clear      = 1'b1;
        end else if (!slip_escape_pending && rx_byte == srd_pkg::SLIP_ESC) begin
          slip_escape_pending_next = 1'b1;
        end else if (slip_escape_pending && rx_byte != srd_pkg::SLIP_ESC_END
                     && rx_byte != srd_pkg::SLIP_ESC_ESC) begin
          has_result = 1'b1;
          rec.kind   = srd_pkg::KIND_ABORT;
          rec.err    = srd_pkg::ERR_DECODE;
          clear      = 1'b1;
        end else if (at_limit) begin
          has_result = 1'b1;
          rec.kind   = srd_pkg::KIND_ABORT;
          rec.err    = srd_pkg::ERR_OVERFLOW;
          clear      = 1'b1;
        end else begin
          has_result               = 1'b1;
          slip_escape_pending_next = 1'b0;
          frame_length_next        = frame_length + 1'b1;
          decoded_nonempty_next    = 1'b1;
          if (slip_escape_pending) begin
            rec.data = (rx_byte == srd_pkg::SLIP_ESC_END) ? srd_pkg::SLIP_END
                                                          : srd_pkg::SLIP_ESC;
          end
        end
      end
    endcase

    if (clear) begin
      frame_length_next        = '0;
      slip_escape_pending_next = 1'b0;
      group_bytes_left_next    = 8'd0;
      group_was_full_next      = 1'b0;
      decoded_nonempty_next    = 1'b0;
    end
  end

  assign push = accept && has_result;

  always_ff @(posedge clk) begin
    if (rst || cfg.mode_wr) begin
      frame_length        <= '0;
      slip_escape_pending <= 1'b0;
      group_bytes_left    <= 8'd0;
      group_was_full      <= 1'b0;
      decoded_nonempty    <= 1'b0;
    end else if (accept) begin
      frame_length        <= frame_length_next;
      slip_escape_pending <= slip_escape_pending_next;
      group_bytes_left    <= group_bytes_left_next;
      group_was_full      <= group_was_full_next;
      decoded_nonempty    <= decoded_nonempty_next;
    end
  end

  a_nonempty_has_length: assert property (@(posedge clk) disable iff (rst)
    decoded_nonempty |-> frame_length != '0)
    else $error("decoded byte recorded with zero frame length");

endmodule

### src/srd_queue.sv
module srd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  srd_pkg::rec_t wr_rec,
  input  logic          pop,
  output srd_pkg::rec_t rd_rec,
  output logic          empty,
  output logic          full
);

  srd_pkg::rec_t entries [srd_pkg::QUEUE_DEPTH];
  logic [srd_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [srd_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [srd_pkg::QUEUE_AW:0]   count;

  assign empty  = (count == '0);
  assign full   = (count == (srd_pkg::QUEUE_AW+1)'(srd_pkg::QUEUE_DEPTH));
  assign rd_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (srd_pkg::QUEUE_AW+1)'(push) - (srd_pkg::QUEUE_AW+1)'(pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

### src/srd_back.sv
module srd_back (
  input  logic          clk,
  input  logic          rst,
  input  srd_pkg::rec_t rd_rec,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    result_kind,
  output logic [7:0]    data_byte,
  output logic [1:0]    error_code,
  output logic          last_of_step
);

  logic load;
  logic done_pending;

  assign load = !out_valid || !out_stall;
  assign pop  = load && !done_pending && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      done_pending <= 1'b0;
    end else if (load) begin
      if (done_pending) begin
        out_valid    <= 1'b1;
        done_pending <= 1'b0;
      end else begin
        out_valid    <= !empty;
        done_pending <= !empty && rd_rec.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (done_pending) begin
        result_kind  <= srd_pkg::KIND_DONE;
        data_byte    <= 8'h00;
        error_code   <= srd_pkg::ERR_NONE;
        last_of_step <= 1'b1;
      end else begin
        result_kind  <= rd_rec.kind;
        data_byte    <= (rd_rec.kind == srd_pkg::KIND_DATA) ? rd_rec.data : 8'h00;
        error_code   <= rd_rec.err;
        last_of_step <= !rd_rec.two;
      end
    end
  end

  a_pending_has_output: assert property (@(posedge clk) disable iff (rst)
    done_pending |-> out_valid)
    else $error("frame-done pending without a result held");

  a_first_of_two_is_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_step |-> result_kind == srd_pkg::KIND_DATA && done_pending)
    else $error("non-final result is not a data byte");

endmodule

### src/serial_rx_deframer_core.sv
// Serial receive deframer: takes one received byte per cycle on in_valid/in_stall and
// recovers frames in raw, delimited-line, COBS or SLIP mode (codec_mode). Each byte
// yields up to two results: decoded data bytes stream out as they are known, then a
// frame-done marker, or a frame-abort marker with an error code (length overflow or
// decode failure) after which the sink discards that frame. Empty frames give nothing.
// The front decodes one byte per cycle while the queue is not full; a four-entry queue
// separates it from the output stage, which hands out one result per cycle unless
// out_stall holds it; in raw mode each byte brings a data result and a done marker. Registers
// live at byte addresses 0 (codec_mode), 4 (line_delimiter) and 8 (max_frame_bytes);
// writing codec_mode restarts framing. Write configuration only while idle.
module serial_rx_deframer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  result_kind,
  output logic [7:0]                  data_byte,
  output logic [1:0]                  error_code,
  output logic                        last_of_step
);

  srd_pkg::cfg_t     cfg;
  srd_pkg::mode_t    codec_mode;
  logic [7:0]        line_delimiter;
  logic [15:0]       max_frame_bytes;
  logic              mode_wr;
  srd_pkg::reg_idx_t reg_idx;
  srd_pkg::rec_t     wr_rec;
  srd_pkg::rec_t     rd_rec;
  logic              wr_en;
  logic              accept;
  logic              push;
  logic              pop;
  logic              empty;
  logic              full;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = srd_pkg::reg_idx_t'(paddr[3:2]);
  assign mode_wr = wr_en && (reg_idx == srd_pkg::REG_CODEC_MODE);

  assign cfg = '{mode_wr:         mode_wr,
                 codec_mode:      codec_mode,
                 line_delimiter:  line_delimiter,
                 max_frame_bytes: max_frame_bytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode      <= srd_pkg::MODE_LINE;
      line_delimiter  <= srd_pkg::LINE_DELIM_RESET;
      max_frame_bytes <= srd_pkg::MAX_BYTES_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        srd_pkg::REG_CODEC_MODE: codec_mode      <= srd_pkg::mode_t'(pwdata[1:0]);
        srd_pkg::REG_LINE_DELIM: line_delimiter  <= pwdata[7:0];
        srd_pkg::REG_MAX_BYTES:  max_frame_bytes <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      srd_pkg::REG_CODEC_MODE: prdata = 32'(codec_mode);
      srd_pkg::REG_LINE_DELIM: prdata = 32'(line_delimiter);
      srd_pkg::REG_MAX_BYTES:  prdata = 32'(max_frame_bytes);
      default:                 prdata = 32'd0;
    endcase
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  srd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .rx_byte (rx_byte),
    .push    (push),
    .rec     (wr_rec)
  );

  srd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (rd_rec),
    .empty  (empty),
    .full   (full)
  );

  srd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rd_rec       (rd_rec),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .data_byte    (data_byte),
    .error_code   (error_code),
    .last_of_step (last_of_step)
  );

endmodule

### tb/sv/tb_serial_rx_deframer_core.sv
`timescale 1ns / 1ps

module tb_serial_rx_deframer_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 165;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_t;

  typedef struct packed {
    srd_pkg::kind_t kind;
    logic [7:0]     data;
    srd_pkg::err_t  err;
    logic           last;
  } res_t;

  typedef struct packed {
    logic              is_cfg;
    srd_pkg::reg_idx_t idx;
    logic [31:0]       val;
    logic              typed;
    logic [1:0]        n;
    res_t              r0;
    res_t              r1;
  } row_t;

  localparam res_t NO_RES = '0;

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [srd_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_valid;
  logic                        in_stall;
  logic [7:0]                  rx_byte;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  result_kind;
  logic [7:0]                  data_byte;
  logic [1:0]                  error_code;
  logic                        last_of_step;

  serial_rx_deframer_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .data_byte    (data_byte),
    .error_code   (error_code),
    .last_of_step (last_of_step)
  );

  // deframer shadow state
  srd_pkg::mode_t cur_mode  = srd_pkg::MODE_LINE;
  logic [7:0]     cur_delim = srd_pkg::LINE_DELIM_RESET;
  logic [15:0]    cur_max   = srd_pkg::MAX_BYTES_RESET;
  logic [15:0]    flen      = '0;
  logic           esc       = 1'b0;
  logic [7:0]     grp_left  = '0;
  logic           grp_full  = 1'b0;
  logic           nonempty  = 1'b0;

  res_t        step_res[$];
  res_t        pending_results[$];
  row_t        dir_rows[$];
  logic [7:0]  frame_bytes[$];

  idle_t       idle_mode  = IDLE_NONE;
  int          errors     = 0;
  int          cycles     = 0;
  int          hold_asks  = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;
  res_t        want;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_serial_rx_deframer_core: errors");
      $finish;
    end
  end

  function automatic void clear_frame();
    flen     = '0;
    esc      = 1'b0;
    grp_left = '0;
    grp_full = 1'b0;
    nonempty = 1'b0;
  endfunction

  function automatic void put_res(srd_pkg::kind_t k, logic [7:0] d, srd_pkg::err_t e);
    res_t r;
    r.kind = k;
    r.data = d;
    r.err  = e;
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void abort_frame(srd_pkg::err_t e);
    put_res(srd_pkg::KIND_ABORT, 8'h00, e);
    clear_frame();
  endfunction

  function automatic void close_frame();
    if (nonempty) put_res(srd_pkg::KIND_DONE, 8'h00, srd_pkg::ERR_NONE);
    clear_frame();
  endfunction

  function automatic void store_decoded(logic [7:0] d);
    if (flen >= cur_max) begin
      abort_frame(srd_pkg::ERR_OVERFLOW);
    end else begin
      flen++;
      nonempty = 1'b1;
      put_res(srd_pkg::KIND_DATA, d, srd_pkg::ERR_NONE);
    end
  endfunction

  // results one received byte brings, left in step_res
  function automatic void deframe_byte(logic [7:0] b);
    step_res.delete();
    case (cur_mode)
      srd_pkg::MODE_RAW: begin
        put_res(srd_pkg::KIND_DATA, b, srd_pkg::ERR_NONE);
        put_res(srd_pkg::KIND_DONE, 8'h00, srd_pkg::ERR_NONE);
      end
      srd_pkg::MODE_LINE: begin
        if (b == cur_delim) close_frame();
        else store_decoded(b);
      end
      srd_pkg::MODE_COBS: begin
        if (b == srd_pkg::COBS_END) begin
          if (flen != 0 && grp_left != 0) abort_frame(srd_pkg::ERR_DECODE);
          else close_frame();
        end else if (flen >= cur_max) begin
          abort_frame(srd_pkg::ERR_OVERFLOW);
        end else begin
          if (grp_left == 0) begin
            if (flen != 0 && !grp_full) begin
              nonempty = 1'b1;
              put_res(srd_pkg::KIND_DATA, 8'h00, srd_pkg::ERR_NONE);
            end
            grp_left = b - 8'd1;
            grp_full = (b == srd_pkg::COBS_FULL);
          end else begin
            grp_left--;
            nonempty = 1'b1;
            put_res(srd_pkg::KIND_DATA, b, srd_pkg::ERR_NONE);
          end
          flen++;
        end
      end
      default: begin
        if (b == srd_pkg::SLIP_END) begin
          close_frame();
        end else if (esc) begin
          if (b == srd_pkg::SLIP_ESC_END) begin
            esc = 1'b0;
            store_decoded(srd_pkg::SLIP_END);
          end else if (b == srd_pkg::SLIP_ESC_ESC) begin
            esc = 1'b0;
            store_decoded(srd_pkg::SLIP_ESC);
          end else begin
            abort_frame(srd_pkg::ERR_DECODE);
          end
        end else if (b == srd_pkg::SLIP_ESC) begin
          esc = 1'b1;
        end else begin
          store_decoded(b);
        end
      end
    endcase
    if (step_res.size() != 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 56;
      IDLE_BOTH: return $urandom_range(0, 99) < 6;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_gap();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 56;
      IDLE_BOTH: return $urandom_range(0, 99) < 6;
      default:   return 1'b0;
    endcase
  endfunction

  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_gap();
    end
  end

  always @(posedge clk) begin : check_results
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d data %02h err %0d last %0d",
                 $time, result_kind, data_byte, error_code, last_of_step);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result_kind !== want.kind) begin
          $display("%0t: result_kind expected %0d got %0d", $time, want.kind, result_kind);
          errors++;
        end
        if (data_byte !== want.data) begin
          $display("%0t: data_byte expected %02h got %02h", $time, want.data, data_byte);
          errors++;
        end
        if (error_code !== want.err) begin
          $display("%0t: error_code expected %0d got %0d", $time, want.err, error_code);
          errors++;
        end
        if (last_of_step !== want.last) begin
          $display("%0t: last_of_step expected %0d got %0d", $time, want.last, last_of_step);
          errors++;
        end
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic typed, input logic [1:0] n,
                           input res_t r0, input res_t r1);
    while (sender_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    if (typed) begin
      step_res.delete();
      if (n > 0) step_res.push_back(r0);
      if (n > 1) step_res.push_back(r1);
    end
    foreach (step_res[i]) pending_results.push_back(step_res[i]);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input srd_pkg::reg_idx_t idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      srd_pkg::REG_CODEC_MODE: begin
        cur_mode = srd_pkg::mode_t'(v[1:0]);
        clear_frame();
      end
      srd_pkg::REG_LINE_DELIM: cur_delim = v[7:0];
      srd_pkg::REG_MAX_BYTES:  cur_max = v[15:0];
      default: ;
    endcase
  endtask

  function automatic res_t mk(srd_pkg::kind_t k, logic [7:0] d, srd_pkg::err_t e, logic l);
    res_t r;
    r.kind = k;
    r.data = d;
    r.err  = e;
    r.last = l;
    return r;
  endfunction

  function automatic void row_cfg(srd_pkg::reg_idx_t idx, logic [31:0] v);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = v;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_byte(logic [7:0] b, logic typed, logic [1:0] n,
                                   res_t r0, res_t r1);
    row_t r;
    r = '0;
    r.val   = {24'd0, b};
    r.typed = typed;
    r.n     = n;
    r.r0    = r0;
    r.r1    = r1;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_pred(logic [7:0] b);
    row_byte(b, 1'b0, 2'd0, NO_RES, NO_RES);
  endfunction

  task automatic build_frame(input srd_pkg::mode_t m, input logic [7:0] delim);
    int n;
    int ci;
    int code;
    int cut;
    bit long_frame;
    logic [7:0] b;
    frame_bytes.delete();
    case (m)
      srd_pkg::MODE_RAW: begin
        repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      srd_pkg::MODE_LINE: begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) != 0) frame_bytes.push_back(delim);
      end
      srd_pkg::MODE_COBS: begin
        long_frame = ($urandom_range(0, 11) == 0);
        n = long_frame ? $urandom_range(250, 320) : $urandom_range(0, 16);
        ci = 0;
        code = 1;
        frame_bytes.push_back(8'h00);
        repeat (n) begin
          if (long_frame) b = ($urandom_range(0, 499) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
          else b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
          if (b == 8'h00) begin
            frame_bytes[ci] = 8'(code);
            ci = frame_bytes.size();
            frame_bytes.push_back(8'h00);
            code = 1;
          end else begin
            frame_bytes.push_back(b);
            code++;
            if (code == 255) begin
              frame_bytes[ci] = 8'(code);
              ci = frame_bytes.size();
              frame_bytes.push_back(8'h00);
              code = 1;
            end
          end
        end
        frame_bytes[ci] = 8'(code);
        case ($urandom_range(0, 15))
          0: begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
          end
          1: begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            frame_bytes.push_back(srd_pkg::COBS_END);
          end
          default: frame_bytes.push_back(srd_pkg::COBS_END);
        endcase
      end
      default: begin
        n = $urandom_range(0, 14);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0:       b = srd_pkg::SLIP_END;
            1:       b = srd_pkg::SLIP_ESC;
            default: b = 8'($urandom_range(0, 255));
          endcase
          if (b == srd_pkg::SLIP_END) begin
            frame_bytes.push_back(srd_pkg::SLIP_ESC);
            frame_bytes.push_back(srd_pkg::SLIP_ESC_END);
          end else if (b == srd_pkg::SLIP_ESC) begin
            frame_bytes.push_back(srd_pkg::SLIP_ESC);
            frame_bytes.push_back(srd_pkg::SLIP_ESC_ESC);
          end else begin
            frame_bytes.push_back(b);
          end
          if ($urandom_range(0, 39) == 0) begin
            frame_bytes.push_back(srd_pkg::SLIP_ESC);
            frame_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
        if ($urandom_range(0, 11) == 0) frame_bytes.push_back(srd_pkg::SLIP_ESC);
        frame_bytes.push_back(srd_pkg::SLIP_END);
      end
    endcase
  endtask

  task automatic run_phase(input srd_pkg::mode_t m, input logic [7:0] delim,
                           input logic [15:0] maxb, input idle_t idl, input bit pressure);
    int sent;
    bit paused;
    settle();
    write_reg(srd_pkg::REG_LINE_DELIM, {24'd0, delim});
    write_reg(srd_pkg::REG_MAX_BYTES, {16'd0, maxb});
    write_reg(srd_pkg::REG_CODEC_MODE, {30'd0, m});
    idle_mode = idl;
    if (pressure) hold_asks++;
    sent = 0;
    paused = 1'b0;
    while (sent < PHASE_ITEMS) begin
      build_frame(m, delim);
      foreach (frame_bytes[k]) send_byte(frame_bytes[k], 1'b0, 2'd0, NO_RES, NO_RES);
      sent += frame_bytes.size();
      if (pressure && !paused && sent >= PHASE_ITEMS / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
      end
    end
    idle_mode = IDLE_NONE;
  endtask

  initial begin
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    rx_byte   = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // line mode out of reset, delimiter 0x0A
    row_byte(8'h41, 1'b1, 2'd1,
             mk(srd_pkg::KIND_DATA, 8'h41, srd_pkg::ERR_NONE, 1'b1), NO_RES);
    row_byte(8'h0A, 1'b1, 2'd1,
             mk(srd_pkg::KIND_DONE, 8'h00, srd_pkg::ERR_NONE, 1'b1), NO_RES);
    row_byte(8'h0A, 1'b1, 2'd0, NO_RES, NO_RES);
    row_cfg(srd_pkg::REG_MAX_BYTES, 32'd1);
    row_byte(8'h01, 1'b1, 2'd1,
             mk(srd_pkg::KIND_DATA, 8'h01, srd_pkg::ERR_NONE, 1'b1), NO_RES);
    row_byte(8'h02, 1'b1, 2'd1,
             mk(srd_pkg::KIND_ABORT, 8'h00, srd_pkg::ERR_OVERFLOW, 1'b1), NO_RES);
    row_byte(8'h0A, 1'b1, 2'd0, NO_RES, NO_RES);
    row_cfg(srd_pkg::REG_CODEC_MODE, {30'd0, srd_pkg::MODE_RAW});
    row_byte(8'h00, 1'b1, 2'd2, mk(srd_pkg::KIND_DATA, 8'h00, srd_pkg::ERR_NONE, 1'b0),
             mk(srd_pkg::KIND_DONE, 8'h00, srd_pkg::ERR_NONE, 1'b1));
    row_byte(8'hFF, 1'b1, 2'd2, mk(srd_pkg::KIND_DATA, 8'hFF, srd_pkg::ERR_NONE, 1'b0),
             mk(srd_pkg::KIND_DONE, 8'h00, srd_pkg::ERR_NONE, 1'b1));
    row_cfg(srd_pkg::REG_MAX_BYTES, 32'd65535);
    row_cfg(srd_pkg::REG_CODEC_MODE, {30'd0, srd_pkg::MODE_COBS});
    row_pred(8'h02);
    row_pred(8'h11);
    row_pred(8'h02);
    row_pred(8'h33);
    row_pred(8'h00);
    row_byte(8'h00, 1'b1, 2'd0, NO_RES, NO_RES);
    row_pred(8'h03);
    row_pred(8'h11);
    row_byte(8'h00, 1'b1, 2'd1,
             mk(srd_pkg::KIND_ABORT, 8'h00, srd_pkg::ERR_DECODE, 1'b1), NO_RES);
    row_cfg(srd_pkg::REG_CODEC_MODE, {30'd0, srd_pkg::MODE_SLIP});
    row_pred(8'hDB);
    row_pred(8'hDC);
    row_pred(8'hC0);
    row_pred(8'hDB);
    row_byte(8'h41, 1'b1, 2'd1,
             mk(srd_pkg::KIND_ABORT, 8'h00, srd_pkg::ERR_DECODE, 1'b1), NO_RES);
    row_pred(8'hDB);
    row_byte(8'hC0, 1'b1, 2'd0, NO_RES, NO_RES);
    row_cfg(srd_pkg::REG_LINE_DELIM, 32'hFF);
    row_cfg(srd_pkg::REG_CODEC_MODE, {30'd0, srd_pkg::MODE_LINE});
    row_byte(8'h00, 1'b1, 2'd1,
             mk(srd_pkg::KIND_DATA, 8'h00, srd_pkg::ERR_NONE, 1'b1), NO_RES);
    row_byte(8'hFF, 1'b1, 2'd1,
             mk(srd_pkg::KIND_DONE, 8'h00, srd_pkg::ERR_NONE, 1'b1), NO_RES);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_byte(dir_rows[i].val[7:0], dir_rows[i].typed, dir_rows[i].n,
                  dir_rows[i].r0, dir_rows[i].r1);
      end
    end

    run_phase(srd_pkg::MODE_LINE, 8'h0A, 16'd2048,  IDLE_NONE, 1'b1);
    run_phase(srd_pkg::MODE_LINE, 8'h00, 16'd3,     IDLE_SEND, 1'b0);
    run_phase(srd_pkg::MODE_LINE, 8'hFF, 16'd65535, IDLE_RECV, 1'b0);
    run_phase(srd_pkg::MODE_RAW,  8'h0A, 16'd2048,  IDLE_BOTH, 1'b0);
    run_phase(srd_pkg::MODE_COBS, 8'h0A, 16'd65535, IDLE_NONE, 1'b0);
    run_phase(srd_pkg::MODE_COBS, 8'h0A, 16'd5,     IDLE_SEND, 1'b0);
    run_phase(srd_pkg::MODE_COBS, 8'h0A, 16'd300,   IDLE_RECV, 1'b0);
    run_phase(srd_pkg::MODE_SLIP, 8'h0A, 16'd2048,  IDLE_BOTH, 1'b0);
    run_phase(srd_pkg::MODE_SLIP, 8'h0A, 16'd1,     IDLE_SEND, 1'b0);
    run_phase(srd_pkg::MODE_RAW,  8'h0A, 16'd2048,  IDLE_RECV, 1'b0);

    settle();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("tb_serial_rx_deframer_core: clean");
    end else begin
      $display("tb_serial_rx_deframer_core: errors");
    end
    $finish;
  end

endmodule
